@@ src/five_point_stencil_center_minus_mean_assert.svh @@
// Assertion macros used by the stencil block's top module.
`ifndef FIVE_POINT_STENCIL_CENTER_MINUS_MEAN_ASSERT_SVH
`define FIVE_POINT_STENCIL_CENTER_MINUS_MEAN_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FPSCM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stencil assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FPSCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stencil assertion failed");

`endif

@@ src/fpscm_pkg.sv @@
// Shared types, constants and register codes of the five-point stencil block.
package fpscm_pkg;

  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned SCALAR_TAIL_DEF = 9;

  localparam int unsigned CELL_W     = 8;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned SUM_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned HEIGHT_W   = 11;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_MODE     = 2'd2;

  // Averaging modes; the unused code behaves like the mixed mode.
  localparam logic [MODE_W-1:0] MODE_MIX    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIV5   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHIFT2 = 2'd2;

  // Register reset values and clamp limits.
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 11'd1024;
  localparam logic [MODE_W-1:0]     MODE_RST   = MODE_MIX;
  localparam int unsigned MIN_WIDTH  = 10;
  localparam int unsigned MIN_HEIGHT = 3;
  localparam int unsigned MAX_HEIGHT = 1024;

  // floor(sum / 5) == (sum * 3277) >> 14 for every sum below 2048.
  localparam int unsigned DIV5_MUL_W = 12;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 12'd3277;
  localparam int unsigned DIV5_SHIFT = 14;

  // The five cells around one interior cell.
  typedef struct packed {
    logic [CELL_W-1:0] center;
    logic [CELL_W-1:0] left;
    logic [CELL_W-1:0] right;
    logic [CELL_W-1:0] up;
    logic [CELL_W-1:0] down;
  } fpscm_window_t;

endpackage

@@ src/fpscm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module fpscm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fpscm_mean.sv @@
// Five-point sum, average by shift or by division by five, and center difference.
module fpscm_mean
  import fpscm_pkg::*;
(
  input  fpscm_window_t     win_i,
  input  logic              use_div_i,
  output logic [CELL_W-1:0] diff_o
);

  localparam int unsigned PROD_W = SUM_W + DIV5_MUL_W;

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [CELL_W-1:0] quot;
  logic [CELL_W-1:0] avg;

  assign sum = SUM_W'(win_i.center) + SUM_W'(win_i.left) + SUM_W'(win_i.right)
             + SUM_W'(win_i.up) + SUM_W'(win_i.down);

  // Reciprocal multiply; the quotient never exceeds 255.
  assign prod = PROD_W'(sum) * PROD_W'(DIV5_MUL);
  assign quot = prod[DIV5_SHIFT +: CELL_W];

  assign avg    = use_div_i ? quot : sum[2 +: CELL_W];
  assign diff_o = win_i.center - avg;

endmodule

@@ src/five_point_stencil_center_minus_mean.sv @@
// Top level of the streaming five-point stencil, center minus neighbor mean.
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       in_valid_i / in_stall_o    cell_in_i, first_of_frame_i
//   out      source     out_valid_o / out_stall_i  cell_out_o, out_row_o, out_col_o,
//                                                  frame_last_o
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item is taken per cycle unless the sweep runs or a stalled output holds the input
// register. The line store reads for an item's column are issued at the edge that
// accepts it, so they have landed while it sits in the input register, and its result
// is loaded into the output register when it advances, unless a stalled result holds
// it back. The rate is set by the single read of each line store copy per cycle.
// After reset the line stores are swept to zero, one entry a cycle; in_stall_o stays
// high during the sweep while configuration writes go on.
// A stalled result does not block the input register until a second item needs
// the output register.
module five_point_stencil_center_minus_mean
  import fpscm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int unsigned SCALAR_TAIL = SCALAR_TAIL_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Cell stream in.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CELL_W-1:0]     cell_in_i,
  input  logic                  first_of_frame_i,
  // Result stream out.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CELL_W-1:0]     cell_out_o,
  output logic [ROW_W-1:0]      out_row_o,
  output logic [COL_W-1:0]      out_col_o,
  output logic                  frame_last_o,
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Column address width, and a comparison width that holds the width register,
  // the largest store size and the tail offset with room to spare.
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int unsigned XW = CW + 7;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] frame_width_q;
  logic [CFG_DATA_W-1:0] frame_height_q;
  logic [MODE_W-1:0]     avg_mode_q;

  // Input register.
  logic              in_valid_q;
  logic [CELL_W-1:0] in_cell_q;
  logic              in_fof_q;

  // Position counters and the left-neighbor register.
  logic [AW-1:0]     col_q;
  logic [ROW_W-1:0]  row_q;
  logic [CELL_W-1:0] left_q;

  // Copies of the store entries that a frame restart needs without a read.
  logic [CELL_W-1:0] prior0_q;
  logic [CELL_W-1:0] prior1_q;
  logic [CELL_W-1:0] older0_q;

  // Clearing sweep.
  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;

  // Output register.
  logic              out_valid_q;
  logic [CELL_W-1:0] out_cell_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic              out_last_q;

  logic                in_accept;
  logic                adv;
  logic [AW-1:0]       col_eff;
  logic [ROW_W-1:0]    row_eff;
  logic [XW-1:0]       col_x;
  logic [XW-1:0]       w_x;
  logic [CW-1:0]       fw_ext;
  logic [CW-1:0]       w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic                row_wrap;
  logic                col_wrap;
  logic [AW-1:0]       col_next;
  logic [ROW_W-1:0]    row_next;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       rd_addr_b;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [CELL_W-1:0]   prior_wdata;
  logic [CELL_W-1:0]   older_wdata;
  logic [CELL_W-1:0]   prior_rd;
  logic [CELL_W-1:0]   prior_rd_b;
  logic [CELL_W-1:0]   older_rd;
  fpscm_window_t       win;
  logic                use_div;
  logic                hit;
  logic [CELL_W-1:0]   diff;
  logic [AW+COL_W-1:0] col_wide;

  // ---------------------------------------------------------------------------
  // Configuration. Writes are always taken; an index past the list is dropped.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WIDTH_RST;
      frame_height_q <= HEIGHT_RST;
      avg_mode_q     <= MODE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_AVG_MODE:     avg_mode_q     <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Width is clamped between MIN_WIDTH and the store size, height between MIN_HEIGHT and the row counter range.
  assign fw_ext = CW'(frame_width_q);
  always_comb begin
    w_eff = fw_ext;
    if (fw_ext < CW'(MIN_WIDTH)) begin
      w_eff = CW'(MIN_WIDTH);
    end else if (fw_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end
    h_eff = frame_height_q;
    if (frame_height_q < HEIGHT_W'(MIN_HEIGHT)) begin
      h_eff = HEIGHT_W'(MIN_HEIGHT);
    end else if (frame_height_q > HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. The input register advances whenever the output register is
  // free or being emptied in the same cycle.
  // ---------------------------------------------------------------------------
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clearing_q || (in_valid_q && !adv);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_fof_q   <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
      in_fof_q   <= first_of_frame_i;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_cell_q <= cell_in_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Position of the item in the input register. A frame marker restarts the
  // counters for this very item.
  // ---------------------------------------------------------------------------
  assign col_eff  = in_fof_q ? '0 : col_q;
  assign row_eff  = in_fof_q ? '0 : row_q;
  assign col_x    = XW'(col_eff);
  assign w_x      = XW'(w_eff);
  assign col_wrap = (col_x + XW'(1)) >= w_x;
  assign row_wrap = (HEIGHT_W'(row_eff) + HEIGHT_W'(1)) >= h_eff;
  assign col_next = col_wrap ? '0 : AW'(col_eff + AW'(1));
  assign row_next = row_wrap ? '0 : ROW_W'(row_eff + ROW_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (adv) begin
      col_q  <= col_next;
      left_q <= col_wrap ? '0 : win.center;
      if (col_wrap) begin
        row_q <= row_next;
      end else begin
        row_q <= row_eff;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. The prior row is held twice so that the center and right
  // neighbors are read in the same cycle. The read address runs one item ahead:
  // it is the column that the next item will use, so its data is registered by
  // the time that item reaches the input register. Column zero comes from the
  // shadow registers, which covers a frame restart from any column.
  // ---------------------------------------------------------------------------
  assign rd_addr   = adv ? col_next : col_q;
  assign rd_addr_b = (rd_addr == LAST_ADDR) ? '0 : AW'(rd_addr + AW'(1));

  assign we          = clearing_q || adv;
  assign waddr       = clearing_q ? clr_addr_q : col_eff;
  assign prior_wdata = clearing_q ? '0 : in_cell_q;
  assign older_wdata = clearing_q ? '0 : win.center;

  fpscm_ram #(
    .WIDTH (CELL_W),
    .DEPTH (MAX_WIDTH)
  ) u_prior_center (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (prior_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prior_rd)
  );

  fpscm_ram #(
    .WIDTH (CELL_W),
    .DEPTH (MAX_WIDTH)
  ) u_prior_right (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (prior_wdata),
    .raddr_i (rd_addr_b),
    .rdata_o (prior_rd_b)
  );

  fpscm_ram #(
    .WIDTH (CELL_W),
    .DEPTH (MAX_WIDTH)
  ) u_older (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (older_wdata),
    .raddr_i (rd_addr),
    .rdata_o (older_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      if (clr_addr_q == LAST_ADDR) begin
        clearing_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior0_q <= '0;
      prior1_q <= '0;
      older0_q <= '0;
    end else if (adv) begin
      if (col_eff == '0) begin
        prior0_q <= in_cell_q;
        older0_q <= win.center;
      end
      if (col_eff == AW'(1)) begin
        prior1_q <= in_cell_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Window and result.
  // ---------------------------------------------------------------------------
  always_comb begin
    win.down = in_cell_q;
    win.left = left_q;
    if (col_eff == '0) begin
      win.center = prior0_q;
      win.up     = older0_q;
      win.right  = prior1_q;
    end else begin
      win.center = prior_rd;
      win.up     = older_rd;
      win.right  = (col_eff == LAST_ADDR) ? '0 : prior_rd_b;
    end
  end

  // The mixed mode divides only in the last SCALAR_TAIL columns of a row.
  always_comb begin
    case (avg_mode_q)
      MODE_DIV5:   use_div = 1'b1;
      MODE_SHIFT2: use_div = 1'b0;
      default:     use_div = (col_x + XW'(SCALAR_TAIL)) >= w_x;
    endcase
  end

  // Interior cells only: row r-1 is produced when row r arrives.
  assign hit = (row_eff >= ROW_W'(2)) && (HEIGHT_W'(row_eff) < h_eff) &&
               (col_eff != '0) && ((col_x + XW'(2)) <= w_x);

  fpscm_mean u_mean (
    .win_i     (win),
    .use_div_i (use_div),
    .diff_o    (diff)
  );

  assign col_wide = (AW + COL_W)'(col_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= hit;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && hit) begin
      out_cell_q <= diff;
      out_row_q  <= row_eff - ROW_W'(1);
      out_col_q  <= col_wide[COL_W-1:0];
      out_last_q <= (HEIGHT_W'(row_eff) == (h_eff - HEIGHT_W'(1))) &&
                    ((col_x + XW'(2)) == w_x);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_out_o   = out_cell_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
`include "five_point_stencil_center_minus_mean_assert.svh"

  // The store sweep and the datapath never write in the same cycle.
  `FPSCM_ASSERT_IMPL(a_no_adv_while_clearing, clearing_q, !adv)
  // An interior cell that leaves the input register lands in the output register.
  `FPSCM_ASSERT_NEXT(a_hit_reaches_output, adv && hit, out_valid_o)
  // A frame restart puts the next item at column one.
  `FPSCM_ASSERT_NEXT(a_restart_column, adv && in_fof_q, col_q == AW'(1))

endmodule
